>>> hdl/a2le_pkg.sv
// ----------------------------------------------------------------------------
// a2le_pkg
// Shared types and constants of the 2-bit lookahead ADPCM encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package a2le_pkg;

  localparam int SAMPLE_W = 16;
  localparam int STEP_W   = 15;
  localparam int ERR_W    = 17;
  localparam int PERR_W   = 18;
  localparam int WEIGHT_W = 3;
  localparam int SCORE_W  = 24;

  localparam int STEP_MIN   = 127;
  localparam int STEP_MAX   = 24576;
  localparam int STEP_RESET = 127;
  localparam int MULT_SMALL = 235;
  localparam int MULT_LARGE = 341;
  localparam int HIST_MAX   = 32767;
  localparam int HIST_MIN   = -32768;

  localparam int CODE_SIGN_BIT  = 1;
  localparam int CODE_LARGE_BIT = 0;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_ABS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_VOL = 2'd1;
  localparam logic [WEIGHT_W-1:0]  WEIGHT_ABS_RESET = 3'd1;
  localparam logic [WEIGHT_W-1:0]  WEIGHT_VOL_RESET = 3'd2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic        [STEP_W-1:0]   step_t;
  typedef logic signed [ERR_W-1:0]    err_t;
  typedef logic signed [PERR_W-1:0]   perr_t;
  typedef logic        [SCORE_W-1:0]  score_t;
  typedef logic        [1:0]          code_t;

endpackage

`default_nettype wire

>>> hdl/a2le_step_unit.sv
// ----------------------------------------------------------------------------
// a2le_step_unit
// Shared decoder step: applies one code to a step size and history value,
// registers the clamped next step size and next history.
// ----------------------------------------------------------------------------
`default_nettype none

module a2le_step_unit (
  input  logic              clk,
  input  a2le_pkg::code_t   code,
  input  a2le_pkg::step_t   step,
  input  a2le_pkg::sample_t hist,
  output a2le_pkg::step_t   next_step,
  output a2le_pkg::sample_t next_hist
);

  logic [16:0]        step3;
  logic [16:0]        delta;
  logic signed [18:0] hist_x;
  logic signed [18:0] delta_x;
  logic signed [18:0] hsum;
  logic [8:0]         mult_k;
  logic [23:0]        prod;
  logic [15:0]        prod_hi;
  a2le_pkg::step_t    step_c;
  a2le_pkg::sample_t  hist_c;
  a2le_pkg::step_t    next_step_r;
  a2le_pkg::sample_t  next_hist_r;

  always_comb begin
    step3   = {2'b00, step} + {1'b0, step, 1'b0};
    delta   = code[a2le_pkg::CODE_LARGE_BIT] ? (step3 >> 3) : ({2'b00, step} >> 3);
    hist_x  = $signed({{3{hist[15]}}, hist});
    delta_x = $signed({2'b00, delta});
    if (code[a2le_pkg::CODE_SIGN_BIT]) begin
      hsum = hist_x - delta_x;
    end else begin
      hsum = hist_x + delta_x;
    end
    if (hsum > 19'(a2le_pkg::HIST_MAX)) begin
      hist_c = 16'sh7fff;
    end else if (hsum < 19'(a2le_pkg::HIST_MIN)) begin
      hist_c = 16'sh8000;
    end else begin
      hist_c = hsum[15:0];
    end
    mult_k  = code[a2le_pkg::CODE_LARGE_BIT] ? 9'(a2le_pkg::MULT_LARGE)
                                             : 9'(a2le_pkg::MULT_SMALL);
    prod    = {9'd0, step} * {15'd0, mult_k};
    prod_hi = prod[23:8];
    if (prod_hi < 16'(a2le_pkg::STEP_MIN)) begin
      step_c = 15'(a2le_pkg::STEP_MIN);
    end else if (prod_hi > 16'(a2le_pkg::STEP_MAX)) begin
      step_c = 15'(a2le_pkg::STEP_MAX);
    end else begin
      step_c = prod_hi[14:0];
    end
  end

  always_ff @(posedge clk) begin
    next_step_r <= step_c;
    next_hist_r <= hist_c;
  end

  assign next_step = next_step_r;
  assign next_hist = next_hist_r;

endmodule

`default_nettype wire

>>> hdl/adpcm2_lookahead_encoder_top.sv
// ----------------------------------------------------------------------------
// adpcm2_lookahead_encoder_top
// 2-bit adaptive delta encoder choosing each code by exhaustive lookahead
// search over all code paths, walked depth first through one shared
// decoder step unit.
//
//   channel | direction | handshake        | payload
//   --------+-----------+------------------+-----------------------------------
//   in      | input     | in_valid/stall   | in_sample, in_last_sample
//   out     | output    | out_valid/stall  | out_code, out_reconstructed,
//           |           |                  | out_end_of_stream
//   cfg     | input     | cfg_valid/ready  | cfg_index, cfg_data
//
// Each search node is decoded in EVAL_A and then scored in EVAL_B in the shared
// step unit; each result then passes APPLY_A and APPLY_W (the threshold-coded
// final sample passes THRESH first), and each sample transfers in from IDLE.
// Held samples transfer in from IDLE without starting a search. The input
// stalls while an item is in work; a stalled output holds the sequencer
// before its next result. No clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module adpcm2_lookahead_encoder_top #(
  parameter int SEARCH_DEPTH = 3
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  a2le_pkg::sample_t                    in_sample,
  input  logic                                 in_last_sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output a2le_pkg::code_t                      out_code,
  output a2le_pkg::sample_t                    out_reconstructed,
  output logic                                 out_end_of_stream,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [a2le_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [a2le_pkg::WEIGHT_W-1:0]        cfg_data
);

  localparam int CNT_W = $clog2(SEARCH_DEPTH + 1);
  localparam int IDX_W = (SEARCH_DEPTH > 1) ? $clog2(SEARCH_DEPTH) : 1;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EVAL_A  = 3'd1;
  localparam logic [2:0] S_EVAL_B  = 3'd2;
  localparam logic [2:0] S_THRESH  = 3'd3;
  localparam logic [2:0] S_APPLY_A = 3'd4;
  localparam logic [2:0] S_APPLY_W = 3'd5;

  logic [2:0]                     state_r, state_nxt;
  logic [CNT_W-1:0]               n_r, n_nxt;
  logic [CNT_W-1:0]               lvl_r, lvl_nxt;
  logic                           last_r, last_nxt;
  logic                           final_r, final_nxt;
  a2le_pkg::code_t                code_r, code_nxt;
  a2le_pkg::code_t                best_code_r, best_code_nxt;
  a2le_pkg::score_t               best_r, best_nxt;
  a2le_pkg::step_t                step_r, step_nxt;
  a2le_pkg::sample_t              pred_r, pred_nxt;
  a2le_pkg::perr_t                perr_r, perr_nxt;
  logic [a2le_pkg::WEIGHT_W-1:0]  wa_r, wa_nxt;
  logic [a2le_pkg::WEIGHT_W-1:0]  wv_r, wv_nxt;
  logic                           out_valid_r, out_valid_nxt;
  a2le_pkg::code_t                out_code_r, out_code_nxt;
  a2le_pkg::sample_t              out_rec_r, out_rec_nxt;
  logic                           out_eos_r, out_eos_nxt;

  a2le_pkg::sample_t              win_r [SEARCH_DEPTH];
  a2le_pkg::sample_t              win_nxt [SEARCH_DEPTH];
  a2le_pkg::code_t                dig_r [SEARCH_DEPTH];
  a2le_pkg::code_t                dig_nxt [SEARCH_DEPTH];
  a2le_pkg::step_t                ss_stk_r [SEARCH_DEPTH];
  a2le_pkg::step_t                ss_stk_nxt [SEARCH_DEPTH];
  a2le_pkg::sample_t              h_stk_r [SEARCH_DEPTH];
  a2le_pkg::sample_t              h_stk_nxt [SEARCH_DEPTH];
  a2le_pkg::err_t                 err_stk_r [SEARCH_DEPTH];
  a2le_pkg::err_t                 err_stk_nxt [SEARCH_DEPTH];
  a2le_pkg::score_t               sc_stk_r [SEARCH_DEPTH];
  a2le_pkg::score_t               sc_stk_nxt [SEARCH_DEPTH];

  logic [IDX_W-1:0]   li;
  logic [IDX_W-1:0]   pi;
  logic               at_root;
  logic               at_leaf;
  logic               out_free;
  logic               go_search;
  a2le_pkg::code_t    unit_code;
  a2le_pkg::step_t    unit_step;
  a2le_pkg::sample_t  unit_hist;
  a2le_pkg::step_t    node_step;
  a2le_pkg::sample_t  node_hist;
  a2le_pkg::sample_t  w_lvl;
  a2le_pkg::err_t     err_node;
  a2le_pkg::perr_t    perr_node;
  logic signed [18:0] de_node;
  logic [16:0]        ae;
  logic [18:0]        ad;
  logic [19:0]        ta;
  logic [21:0]        tv;
  a2le_pkg::score_t   parent_sc;
  a2le_pkg::score_t   node_sc;
  logic               better;
  logic               found;
  logic [CNT_W-1:0]   j_sel;
  a2le_pkg::err_t     diff;
  logic [16:0]        adiff;
  logic [18:0]        four_adiff;
  a2le_pkg::err_t     apply_err;

  assign li       = lvl_r[IDX_W-1:0];
  assign pi       = IDX_W'(lvl_r - CNT_W'(1));
  assign at_root  = (lvl_r == '0);
  assign at_leaf  = (CNT_W'(lvl_r + CNT_W'(1)) == n_r);
  assign out_free = !out_valid_r || !out_stall;

  // shared step unit: tree node in EVAL_A, chosen code on base state otherwise
  always_comb begin
    if (state_r == S_EVAL_A) begin
      unit_code = dig_r[li];
      unit_step = at_root ? step_r : ss_stk_r[pi];
      unit_hist = at_root ? pred_r : h_stk_r[pi];
    end else begin
      unit_code = code_r;
      unit_step = step_r;
      unit_hist = pred_r;
    end
  end

  a2le_step_unit u_step (
    .clk       (clk),
    .code      (unit_code),
    .step      (unit_step),
    .hist      (unit_hist),
    .next_step (node_step),
    .next_hist (node_hist)
  );

  // node score
  always_comb begin
    w_lvl     = win_r[li];
    err_node  = $signed({node_hist[15], node_hist}) - $signed({w_lvl[15], w_lvl});
    perr_node = at_root ? perr_r : $signed({err_stk_r[pi][16], err_stk_r[pi]});
    de_node   = $signed({{2{err_node[16]}}, err_node})
              - $signed({perr_node[17], perr_node});
    ae        = err_node[16] ? (~err_node + 17'd1) : err_node;
    ad        = de_node[18] ? (~de_node + 19'd1) : de_node;
    ta        = {17'd0, wa_r} * {3'd0, ae};
    tv        = {19'd0, wv_r} * {3'd0, ad};
    parent_sc = at_root ? '0 : sc_stk_r[pi];
    node_sc   = parent_sc + {4'd0, ta} + {2'd0, tv};
    better    = (node_sc < best_r);
  end

  // deepest level at or above the current one that still has a code to try
  always_comb begin
    found = 1'b0;
    j_sel = '0;
    for (int k = 0; k < SEARCH_DEPTH; k++) begin
      if (CNT_W'(k) <= lvl_r && dig_r[k] != 2'd3) begin
        found = 1'b1;
        j_sel = CNT_W'(k);
      end
    end
  end

  always_comb begin
    diff       = $signed({win_r[0][15], win_r[0]}) - $signed({pred_r[15], pred_r});
    adiff      = diff[16] ? (~diff + 17'd1) : diff;
    four_adiff = {adiff, 2'b00};
    apply_err  = $signed({node_hist[15], node_hist}) - $signed({win_r[0][15], win_r[0]});
  end

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    lvl_nxt       = lvl_r;
    last_nxt      = last_r;
    final_nxt     = final_r;
    code_nxt      = code_r;
    best_code_nxt = best_code_r;
    best_nxt      = best_r;
    step_nxt      = step_r;
    pred_nxt      = pred_r;
    perr_nxt      = perr_r;
    wa_nxt        = wa_r;
    wv_nxt        = wv_r;
    out_valid_nxt = out_valid_r;
    out_code_nxt  = out_code_r;
    out_rec_nxt   = out_rec_r;
    out_eos_nxt   = out_eos_r;
    win_nxt       = win_r;
    dig_nxt       = dig_r;
    ss_stk_nxt    = ss_stk_r;
    h_stk_nxt     = h_stk_r;
    err_stk_nxt   = err_stk_r;
    sc_stk_nxt    = sc_stk_r;
    go_search     = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_valid) begin
      if (cfg_index == a2le_pkg::REG_WEIGHT_ABS) begin
        wa_nxt = cfg_data;
      end else if (cfg_index == a2le_pkg::REG_WEIGHT_VOL) begin
        wv_nxt = cfg_data;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          win_nxt[n_r[IDX_W-1:0]] = in_sample;
          last_nxt  = in_last_sample;
          final_nxt = 1'b0;
          n_nxt     = CNT_W'(n_r + CNT_W'(1));
          if (in_last_sample) begin
            if (n_r == '0) begin
              state_nxt = S_THRESH;
            end else begin
              go_search = 1'b1;
            end
          end else if (CNT_W'(n_r + CNT_W'(1)) == CNT_W'(SEARCH_DEPTH)) begin
            go_search = 1'b1;
          end
        end
      end
      S_EVAL_A: begin
        state_nxt = S_EVAL_B;
      end
      S_EVAL_B: begin
        ss_stk_nxt[li]  = node_step;
        h_stk_nxt[li]   = node_hist;
        err_stk_nxt[li] = err_node;
        sc_stk_nxt[li]  = node_sc;
        if (!at_leaf) begin
          lvl_nxt   = CNT_W'(lvl_r + CNT_W'(1));
          dig_nxt[IDX_W'(lvl_r + CNT_W'(1))] = 2'd0;
          state_nxt = S_EVAL_A;
        end else begin
          if (better) begin
            best_nxt      = node_sc;
            best_code_nxt = dig_r[0];
          end
          if (found) begin
            dig_nxt[j_sel[IDX_W-1:0]] = dig_r[j_sel[IDX_W-1:0]] + 2'd1;
            lvl_nxt   = j_sel;
            state_nxt = S_EVAL_A;
          end else begin
            code_nxt  = better ? dig_r[0] : best_code_r;
            state_nxt = S_APPLY_A;
          end
        end
      end
      S_THRESH: begin
        code_nxt[a2le_pkg::CODE_SIGN_BIT]  = diff[16];
        code_nxt[a2le_pkg::CODE_LARGE_BIT] = (four_adiff >= {4'd0, step_r});
        final_nxt = 1'b1;
        state_nxt = S_APPLY_A;
      end
      S_APPLY_A: begin
        state_nxt = S_APPLY_W;
      end
      S_APPLY_W: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_code_nxt  = code_r;
          out_rec_nxt   = node_hist;
          out_eos_nxt   = final_r;
          if (final_r) begin
            step_nxt  = 15'(a2le_pkg::STEP_RESET);
            pred_nxt  = '0;
            perr_nxt  = '0;
            n_nxt     = '0;
            last_nxt  = 1'b0;
            final_nxt = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            step_nxt = node_step;
            pred_nxt = node_hist;
            perr_nxt = $signed({apply_err[16], apply_err});
            for (int k = 0; k < SEARCH_DEPTH - 1; k++) begin
              win_nxt[k] = win_r[k+1];
            end
            n_nxt = CNT_W'(n_r - CNT_W'(1));
            if (!last_r) begin
              state_nxt = S_IDLE;
            end else if (CNT_W'(n_r - CNT_W'(1)) == CNT_W'(1)) begin
              state_nxt = S_THRESH;
            end else begin
              go_search = 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (go_search) begin
      lvl_nxt       = '0;
      best_nxt      = '1;
      best_code_nxt = 2'd0;
      for (int k = 0; k < SEARCH_DEPTH; k++) begin
        dig_nxt[k] = 2'd0;
      end
      state_nxt = S_EVAL_A;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      n_r         <= '0;
      lvl_r       <= '0;
      last_r      <= 1'b0;
      final_r     <= 1'b0;
      step_r      <= 15'(a2le_pkg::STEP_RESET);
      pred_r      <= '0;
      perr_r      <= '0;
      wa_r        <= a2le_pkg::WEIGHT_ABS_RESET;
      wv_r        <= a2le_pkg::WEIGHT_VOL_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      lvl_r       <= lvl_nxt;
      last_r      <= last_nxt;
      final_r     <= final_nxt;
      step_r      <= step_nxt;
      pred_r      <= pred_nxt;
      perr_r      <= perr_nxt;
      wa_r        <= wa_nxt;
      wv_r        <= wv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r      <= code_nxt;
    best_code_r <= best_code_nxt;
    best_r      <= best_nxt;
    out_code_r  <= out_code_nxt;
    out_rec_r   <= out_rec_nxt;
    out_eos_r   <= out_eos_nxt;
    win_r       <= win_nxt;
    dig_r       <= dig_nxt;
    ss_stk_r    <= ss_stk_nxt;
    h_stk_r     <= h_stk_nxt;
    err_stk_r   <= err_stk_nxt;
    sc_stk_r    <= sc_stk_nxt;
  end

  assign in_stall          = (state_r != S_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_code          = out_code_r;
  assign out_reconstructed = out_rec_r;
  assign out_end_of_stream = out_eos_r;

  a_lvl_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL_B) |-> (lvl_r < n_r))
    else $error("search level beyond held window");

  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r >= 15'(a2le_pkg::STEP_MIN)) && (step_r <= 15'(a2le_pkg::STEP_MAX)))
    else $error("step size out of range");

  a_stream_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APPLY_W && out_free && final_r)
      |=> (state_r == S_IDLE && n_r == '0 && pred_r == '0 && out_eos_r))
    else $error("state not reset after final result");

endmodule

`default_nettype wire

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 2-bit lookahead ADPCM encoder. Streams of
// samples go in over the stalled input channel; a behavioral encoder with its
// own step size, history, carried error and held samples predicts every code,
// reconstructed value and end mark. Results are compared in order. Weight
// registers are swept between segments, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     DEPTH         = 3;
  localparam int     CYCLE_LIMIT   = 1_000_000;
  localparam int     SETTLE_CYCLES = 400;
  localparam int     RANDOM_ITEMS  = 400;
  localparam int     SEGMENTS      = 6;
  localparam int     TABLE_ROWS    = 24;
  localparam longint SCORE_CEILING = 64'h7FFF_FFFF_FFFF_FFFF;

  localparam a2le_pkg::code_t CODE_ADD_SMALL = 2'b00;
  localparam a2le_pkg::code_t CODE_ADD_LARGE = 2'b01;
  localparam a2le_pkg::code_t CODE_SUB_SMALL = 2'b10;
  localparam a2le_pkg::code_t CODE_SUB_LARGE = 2'b11;

  localparam logic [a2le_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [a2le_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef enum int {STYLE_NOISE, STYLE_NEAR_LEVEL, STYLE_SQUARE, STYLE_RAMP} wave_style_t;

  typedef struct packed {
    a2le_pkg::code_t   code;
    a2le_pkg::sample_t recon;
    logic              eos;
  } enc_result_t;

  typedef struct packed {
    a2le_pkg::sample_t sample;
    logic              last;
    logic              typed;
    a2le_pkg::code_t   code;
    a2le_pkg::sample_t recon;
  } stim_row_t;

  logic                                 clk            = 1'b0;
  logic                                 rst_n          = 1'b0;
  logic                                 in_valid       = 1'b0;
  logic                                 in_stall;
  a2le_pkg::sample_t                    in_sample      = '0;
  logic                                 in_last_sample = 1'b0;
  logic                                 out_valid;
  logic                                 out_stall      = 1'b0;
  a2le_pkg::code_t                      out_code;
  a2le_pkg::sample_t                    out_reconstructed;
  logic                                 out_end_of_stream;
  logic                                 cfg_valid      = 1'b0;
  logic                                 cfg_ready;
  logic [a2le_pkg::CFG_IDX_W-1:0]       cfg_index      = '0;
  logic [a2le_pkg::WEIGHT_W-1:0]        cfg_data       = '0;

  logic [a2le_pkg::WEIGHT_W-1:0] w_abs = a2le_pkg::WEIGHT_ABS_RESET;
  logic [a2le_pkg::WEIGHT_W-1:0] w_vol = a2le_pkg::WEIGHT_VOL_RESET;
  a2le_pkg::step_t               enc_step = a2le_pkg::step_t'(a2le_pkg::STEP_RESET);
  a2le_pkg::sample_t             enc_hist = '0;
  a2le_pkg::perr_t               enc_err  = '0;
  a2le_pkg::sample_t             held [DEPTH-1];
  int                            held_count = 0;
  int                            search_win [DEPTH];
  enc_result_t                   pending_codes [$];
  stim_row_t                     stim_table [TABLE_ROWS];

  int          fail_count    = 0;
  int unsigned cycle_count   = 0;
  int          send_idle_pct = 32;
  int          recv_idle_pct = 66;

  adpcm2_lookahead_encoder_top #(
    .SEARCH_DEPTH(DEPTH)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample        (in_sample),
    .in_last_sample   (in_last_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_code         (out_code),
    .out_reconstructed(out_reconstructed),
    .out_end_of_stream(out_end_of_stream),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void decode_code(input a2le_pkg::code_t c, input int ss,
                                      input int hist, output int nss, output int nhist);
    int delta;
    int ns;
    int h;
    delta = ((c[a2le_pkg::CODE_LARGE_BIT] ? 3 : 1) * ss) >>> 3;
    ns    = ((c[a2le_pkg::CODE_LARGE_BIT] ? a2le_pkg::MULT_LARGE : a2le_pkg::MULT_SMALL)
             * ss) >>> 8;
    if (delta > a2le_pkg::HIST_MAX) delta = a2le_pkg::HIST_MAX;
    h = c[a2le_pkg::CODE_SIGN_BIT] ? hist - delta : hist + delta;
    nss   = (ns > a2le_pkg::STEP_MAX) ? a2le_pkg::STEP_MAX
          : ((ns < a2le_pkg::STEP_MIN) ? a2le_pkg::STEP_MIN : ns);
    nhist = (h > a2le_pkg::HIST_MAX) ? a2le_pkg::HIST_MAX
          : ((h < a2le_pkg::HIST_MIN) ? a2le_pkg::HIST_MIN : h);
  endfunction

  function automatic longint path_cost(input int err, input int perr);
    int jump;
    jump = err - perr;
    return longint'(w_abs) * longint'(err < 0 ? -err : err)
         + longint'(w_vol) * longint'(jump < 0 ? -jump : jump);
  endfunction

  // exhaustive search over the window search_win[first .. n-1]
  function automatic a2le_pkg::code_t pick_code(input int first, input int n);
    longint          best_total;
    longint          best_path;
    longint          total;
    int              len;
    int              ss;
    int              hist;
    int              perr;
    int              nss;
    int              nh;
    int              err;
    a2le_pkg::code_t best_c;
    len        = n - first;
    best_total = SCORE_CEILING;
    best_c     = CODE_ADD_SMALL;
    for (int k = 0; k < 4; k++) begin
      best_path = SCORE_CEILING;
      for (int p = 0; p < (1 << (2 * (len - 1))); p++) begin
        decode_code(a2le_pkg::code_t'(k), int'(enc_step), int'(enc_hist), ss, hist);
        perr  = hist - search_win[first];
        total = path_cost(perr, int'(enc_err));
        for (int j = 1; j < len; j++) begin
          decode_code(a2le_pkg::code_t'(p >> (2 * (j - 1))), ss, hist, nss, nh);
          err   = nh - search_win[first + j];
          total = total + path_cost(err, perr);
          perr  = err;
          ss    = nss;
          hist  = nh;
        end
        if (total < best_path) best_path = total;
      end
      if (best_path < best_total) begin
        best_total = best_path;
        best_c     = a2le_pkg::code_t'(k);
      end
    end
    return best_c;
  endfunction

  function automatic void commit_code(input a2le_pkg::code_t c, input int x, input logic eos);
    int nss;
    int nh;
    enc_result_t r;
    decode_code(c, int'(enc_step), int'(enc_hist), nss, nh);
    enc_step = a2le_pkg::step_t'(nss);
    enc_hist = a2le_pkg::sample_t'(nh);
    enc_err  = a2le_pkg::perr_t'(nh - x);
    r.code   = c;
    r.recon  = a2le_pkg::sample_t'(nh);
    r.eos    = eos;
    pending_codes.push_back(r);
  endfunction

  function automatic void clear_stream();
    held_count = 0;
    foreach (held[i]) held[i] = '0;
    enc_step = a2le_pkg::step_t'(a2le_pkg::STEP_RESET);
    enc_hist = '0;
    enc_err  = '0;
  endfunction

  function automatic void encode_sample(input a2le_pkg::sample_t s, input logic last);
    int              n;
    int              diff;
    a2le_pkg::code_t c;
    for (int i = 0; i < held_count; i++) search_win[i] = int'(held[i]);
    search_win[held_count] = int'(s);
    n = held_count + 1;
    if (last) begin
      for (int i = 0; i < n - 1; i++) commit_code(pick_code(i, n), search_win[i], 1'b0);
      diff = int'(s) - int'(enc_hist);
      c = (4 * (diff < 0 ? -diff : diff) >= int'(enc_step)) ? CODE_ADD_LARGE
                                                            : CODE_ADD_SMALL;
      if (diff < 0) c[a2le_pkg::CODE_SIGN_BIT] = 1'b1;
      commit_code(c, int'(s), 1'b1);
      clear_stream();
    end else if (n < DEPTH) begin
      held[held_count] = s;
      held_count++;
    end else begin
      commit_code(pick_code(0, n), search_win[0], 1'b0);
      for (int i = 1; i < n; i++) held[i-1] = a2le_pkg::sample_t'(search_win[i]);
      held_count = n - 1;
    end
  endfunction

  task automatic send_item(input a2le_pkg::sample_t s, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_sample      <= s;
    in_last_sample <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    encode_sample(s, last);
  endtask

  task automatic write_reg(input logic [a2le_pkg::CFG_IDX_W-1:0] idx,
                           input logic [a2le_pkg::WEIGHT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == a2le_pkg::REG_WEIGHT_ABS) w_abs = data;
    else if (idx == a2le_pkg::REG_WEIGHT_VOL) w_vol = data;
  endtask

  task automatic set_weights(input logic [a2le_pkg::WEIGHT_W-1:0] wa,
                             input logic [a2le_pkg::WEIGHT_W-1:0] wv,
                             input logic touch_spare);
    in_valid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (touch_spare) begin
      write_reg(REG_SPARE_2, a2le_pkg::WEIGHT_W'($urandom));
      write_reg(REG_SPARE_3, a2le_pkg::WEIGHT_W'($urandom));
    end
    write_reg(a2le_pkg::REG_WEIGHT_ABS, wa);
    write_reg(a2le_pkg::REG_WEIGHT_VOL, wv);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_stream(inout int count);
    wave_style_t style;
    int          len;
    int          level;
    int          slope;
    int          amp;
    int          hold;
    int          v;
    logic        high_side;
    style     = wave_style_t'($urandom_range(3));
    len       = ($urandom_range(7) == 0) ? $urandom_range(60, 25) : $urandom_range(24, 1);
    level     = int'($urandom_range(65535)) - 32768;
    slope     = int'($urandom_range(4000)) - 2000;
    amp       = 1 << $urandom_range(12);
    hold      = $urandom_range(30, 1);
    high_side = 1'($urandom_range(1));
    for (int k = 0; k < len; k++) begin
      case (style)
        STYLE_NOISE: begin
          if ($urandom_range(7) == 0) begin
            case ($urandom_range(2))
              0:       v = a2le_pkg::HIST_MAX;
              1:       v = a2le_pkg::HIST_MIN;
              default: v = 0;
            endcase
          end else begin
            v = int'($urandom_range(65535)) - 32768;
          end
        end
        STYLE_NEAR_LEVEL: v = level + int'($urandom_range(2 * amp)) - amp;
        STYLE_SQUARE: begin
          if (k % hold == 0) high_side = ~high_side;
          v = high_side ? a2le_pkg::HIST_MAX : a2le_pkg::HIST_MIN;
        end
        default: begin
          level = level + slope;
          v     = level;
        end
      endcase
      v = (v > a2le_pkg::HIST_MAX) ? a2le_pkg::HIST_MAX
        : ((v < a2le_pkg::HIST_MIN) ? a2le_pkg::HIST_MIN : v);
      send_item(a2le_pkg::sample_t'(v), k == len - 1);
      count++;
    end
  endtask

  always @(posedge clk) cycle_count <= cycle_count + 1;

  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_idle_pct);

  always @(posedge clk) begin : check_codes
    enc_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_codes.size() == 0) begin
        $error("unexpected transfer: code %0d, reconstructed %0d", out_code,
               out_reconstructed);
        fail_count++;
      end else begin
        want = pending_codes.pop_front();
        if (out_code !== want.code) begin
          $error("code: expected %0d, got %0d", want.code, out_code);
          fail_count++;
        end
        if (out_reconstructed !== want.recon) begin
          $error("reconstructed: expected %0d, got %0d", want.recon, out_reconstructed);
          fail_count++;
        end
        if (out_end_of_stream !== want.eos) begin
          $error("end_of_stream: expected %0d, got %0d", want.eos, out_end_of_stream);
          fail_count++;
        end
      end
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int          items;
    enc_result_t typed_r;
    stim_table = '{
      '{a2le_pkg::sample_t'(0),      1'b1, 1'b1, CODE_ADD_SMALL, a2le_pkg::sample_t'(15)},
      '{a2le_pkg::sample_t'(31),     1'b1, 1'b1, CODE_ADD_SMALL, a2le_pkg::sample_t'(15)},
      '{a2le_pkg::sample_t'(32),     1'b1, 1'b1, CODE_ADD_LARGE, a2le_pkg::sample_t'(47)},
      '{a2le_pkg::sample_t'(-31),    1'b1, 1'b1, CODE_SUB_SMALL, a2le_pkg::sample_t'(-15)},
      '{a2le_pkg::sample_t'(a2le_pkg::HIST_MIN), 1'b1, 1'b1, CODE_SUB_LARGE,
        a2le_pkg::sample_t'(-47)},
      '{a2le_pkg::sample_t'(a2le_pkg::HIST_MAX), 1'b1, 1'b1, CODE_ADD_LARGE,
        a2le_pkg::sample_t'(47)},
      '{a2le_pkg::sample_t'(a2le_pkg::HIST_MAX), 1'b0, 1'b0, CODE_ADD_SMALL, '0},
      '{a2le_pkg::sample_t'(a2le_pkg::HIST_MAX), 1'b0, 1'b0, CODE_ADD_SMALL, '0},
      '{a2le_pkg::sample_t'(a2le_pkg::HIST_MAX), 1'b0, 1'b0, CODE_ADD_SMALL, '0},
      '{a2le_pkg::sample_t'(a2le_pkg::HIST_MAX), 1'b0, 1'b0, CODE_ADD_SMALL, '0},
      '{a2le_pkg::sample_t'(a2le_pkg::HIST_MAX), 1'b0, 1'b0, CODE_ADD_SMALL, '0},
      '{a2le_pkg::sample_t'(a2le_pkg::HIST_MAX), 1'b0, 1'b0, CODE_ADD_SMALL, '0},
      '{a2le_pkg::sample_t'(a2le_pkg::HIST_MAX), 1'b0, 1'b0, CODE_ADD_SMALL, '0},
      '{a2le_pkg::sample_t'(a2le_pkg::HIST_MIN), 1'b0, 1'b0, CODE_ADD_SMALL, '0},
      '{a2le_pkg::sample_t'(a2le_pkg::HIST_MIN), 1'b0, 1'b0, CODE_ADD_SMALL, '0},
      '{a2le_pkg::sample_t'(a2le_pkg::HIST_MIN), 1'b0, 1'b0, CODE_ADD_SMALL, '0},
      '{a2le_pkg::sample_t'(a2le_pkg::HIST_MIN), 1'b0, 1'b0, CODE_ADD_SMALL, '0},
      '{a2le_pkg::sample_t'(a2le_pkg::HIST_MIN), 1'b0, 1'b0, CODE_ADD_SMALL, '0},
      '{a2le_pkg::sample_t'(0),      1'b1, 1'b0, CODE_ADD_SMALL, '0},
      '{a2le_pkg::sample_t'(1000),   1'b0, 1'b0, CODE_ADD_SMALL, '0},
      '{a2le_pkg::sample_t'(-1000),  1'b1, 1'b0, CODE_ADD_SMALL, '0},
      '{a2le_pkg::sample_t'(5),      1'b0, 1'b0, CODE_ADD_SMALL, '0},
      '{a2le_pkg::sample_t'(7),      1'b0, 1'b0, CODE_ADD_SMALL, '0},
      '{a2le_pkg::sample_t'(-9),     1'b1, 1'b0, CODE_ADD_SMALL, '0}
    };
    clear_stream();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_table[i]) begin
      send_item(stim_table[i].sample, stim_table[i].last);
      if (stim_table[i].typed) begin
        void'(pending_codes.pop_back());
        typed_r.code  = stim_table[i].code;
        typed_r.recon = stim_table[i].recon;
        typed_r.eos   = 1'b1;
        pending_codes.push_back(typed_r);
      end
    end

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 2)
        0: begin
          send_idle_pct = 32;
          recv_idle_pct = 66;
        end
        1: begin
          send_idle_pct = 66;
          recv_idle_pct = 32;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (seg)
        0:       set_weights(3'd0, 3'd0, 1'b1);
        1:       set_weights(3'd7, 3'd7, 1'b0);
        2:       set_weights(3'd0, 3'd7, 1'b0);
        3:       set_weights(3'd7, 3'd0, 1'b0);
        default: set_weights(a2le_pkg::WEIGHT_W'($urandom_range(7)),
                             a2le_pkg::WEIGHT_W'($urandom_range(7)), 1'b0);
      endcase
      items = 0;
      while (items < RANDOM_ITEMS / SEGMENTS) send_stream(items);
    end

    in_valid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
